@@ hw/rtl/acmc_pkg.sv @@
// Shared types and constants of the coverage-preserving mip chain builder.
package acmc_pkg;

  localparam int TEXEL_W    = 32;
  localparam int SCALE_FRAC = 17;
  localparam int SCW        = 21;
  localparam logic [SCW-1:0] SCALE_TOP = SCW'(1) << 20;
  localparam logic [SCW+7:0] CUT_LIMIT = (SCW+8)'(255) << (SCALE_FRAC - 1);
  localparam logic [SCW+7:0] ROUND_HALF = (SCW+8)'(1) << (SCALE_FRAC - 1);

  typedef enum logic [1:0] {
    SW_BASE,
    SW_COUNT,
    SW_APPLY
  } sw_kind_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_LOOK,
    ST_RD_MUL,
    ST_RD_ADDR,
    ST_RD_WAIT,
    ST_RD_OUT,
    ST_BC_START,
    ST_BC_SWEEP,
    ST_LV_CHECK,
    ST_LV_INIT,
    ST_LV_DN,
    ST_LV_TGT,
    ST_FL_R0,
    ST_FL_R1,
    ST_FL_R2,
    ST_FL_R3,
    ST_FL_ACC,
    ST_FL_WRITE,
    ST_BS_INIT,
    ST_BS_MID,
    ST_BS_SWEEP,
    ST_BS_MUL,
    ST_BS_UPD,
    ST_SEL_START,
    ST_SEL_SWEEP,
    ST_SEL_MUL,
    ST_SEL_ABS,
    ST_SEL_DEC,
    ST_AP_START,
    ST_AP_SWEEP,
    ST_LV_NEXT
  } st_t;

  typedef struct packed {
    logic       load;
    logic       build_init;
    logic       sw_start;
    sw_kind_t   kind;
    logic       lv_init;
    logic       lv_dn;
    logic       lv_tgt;
    logic       fl_read;
    logic [1:0] fl_k;
    logic       fl_clr;
    logic       fl_acc;
    logic       fl_write;
    logic       bs_init;
    logic       bs_mid;
    logic       bs_mul;
    logic       bs_upd;
    logic       sel_load;
    logic       sel_mul;
    logic       sel_abs;
    logic       sel_dec;
    logic       lv_next;
    logic       rd_latch;
    logic       rd_look;
    logic       rd_mul;
    logic       rd_issue;
    logic       rd_out;
  } acmc_cmd_t;

  typedef struct packed {
    logic sw_busy;
    logic fl_last;
    logic bs_last;
    logic more;
    logic out_free;
  } acmc_status_t;

endpackage

@@ hw/rtl/acmc_ram.sv @@
// Generic simple dual-port RAM with registered read data.
module acmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/acmc_ctrl.sv @@
// Sequencer of the mip chain builder: loads, reads and the per-level build steps.
module acmc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   mode,
  input  logic                   last_texel,
  input  acmc_pkg::acmc_status_t status,
  output acmc_pkg::acmc_cmd_t    cmd,
  output logic                   s_tready
);
  import acmc_pkg::*;

  st_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.kind   = SW_COUNT;
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (!mode) begin
            cmd.load = 1'b1;
            if (last_texel) begin
              cmd.build_init = 1'b1;
              state_next     = ST_BC_START;
            end
          end else begin
            cmd.rd_latch = 1'b1;
            state_next   = ST_RD_LOOK;
          end
        end
      end
      ST_RD_LOOK: begin
        cmd.rd_look = 1'b1;
        state_next  = ST_RD_MUL;
      end
      ST_RD_MUL: begin
        cmd.rd_mul = 1'b1;
        state_next = ST_RD_ADDR;
      end
      ST_RD_ADDR: begin
        cmd.rd_issue = 1'b1;
        state_next   = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        state_next = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        if (status.out_free) begin
          cmd.rd_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_BC_START: begin
        cmd.sw_start = 1'b1;
        cmd.kind     = SW_BASE;
        state_next   = ST_BC_SWEEP;
      end
      ST_BC_SWEEP: begin
        cmd.kind = SW_BASE;
        if (!status.sw_busy) begin
          state_next = ST_LV_CHECK;
        end
      end
      ST_LV_CHECK: begin
        state_next = status.more ? ST_LV_INIT : ST_IDLE;
      end
      ST_LV_INIT: begin
        cmd.lv_init = 1'b1;
        state_next  = ST_LV_DN;
      end
      ST_LV_DN: begin
        cmd.lv_dn  = 1'b1;
        state_next = ST_LV_TGT;
      end
      ST_LV_TGT: begin
        cmd.lv_tgt = 1'b1;
        state_next = ST_FL_R0;
      end
      ST_FL_R0: begin
        cmd.fl_read = 1'b1;
        cmd.fl_k    = 2'd0;
        cmd.fl_clr  = 1'b1;
        state_next  = ST_FL_R1;
      end
      ST_FL_R1: begin
        cmd.fl_read = 1'b1;
        cmd.fl_k    = 2'd1;
        cmd.fl_acc  = 1'b1;
        state_next  = ST_FL_R2;
      end
      ST_FL_R2: begin
        cmd.fl_read = 1'b1;
        cmd.fl_k    = 2'd2;
        cmd.fl_acc  = 1'b1;
        state_next  = ST_FL_R3;
      end
      ST_FL_R3: begin
        cmd.fl_read = 1'b1;
        cmd.fl_k    = 2'd3;
        cmd.fl_acc  = 1'b1;
        state_next  = ST_FL_ACC;
      end
      ST_FL_ACC: begin
        cmd.fl_acc = 1'b1;
        state_next = ST_FL_WRITE;
      end
      ST_FL_WRITE: begin
        cmd.fl_write = 1'b1;
        state_next   = status.fl_last ? ST_BS_INIT : ST_FL_R0;
      end
      ST_BS_INIT: begin
        cmd.bs_init = 1'b1;
        state_next  = ST_BS_MID;
      end
      ST_BS_MID: begin
        cmd.bs_mid   = 1'b1;
        cmd.sw_start = 1'b1;
        state_next   = ST_BS_SWEEP;
      end
      ST_BS_SWEEP: begin
        if (!status.sw_busy) begin
          state_next = ST_BS_MUL;
        end
      end
      ST_BS_MUL: begin
        cmd.bs_mul = 1'b1;
        state_next = ST_BS_UPD;
      end
      ST_BS_UPD: begin
        cmd.bs_upd = 1'b1;
        state_next = status.bs_last ? ST_SEL_START : ST_BS_MID;
      end
      ST_SEL_START: begin
        cmd.sel_load = 1'b1;
        cmd.sw_start = 1'b1;
        state_next   = ST_SEL_SWEEP;
      end
      ST_SEL_SWEEP: begin
        if (!status.sw_busy) begin
          state_next = ST_SEL_MUL;
        end
      end
      ST_SEL_MUL: begin
        cmd.sel_mul = 1'b1;
        state_next  = ST_SEL_ABS;
      end
      ST_SEL_ABS: begin
        cmd.sel_abs = 1'b1;
        state_next  = ST_SEL_DEC;
      end
      ST_SEL_DEC: begin
        cmd.sel_dec = 1'b1;
        state_next  = ST_AP_START;
      end
      ST_AP_START: begin
        cmd.sw_start = 1'b1;
        cmd.kind     = SW_APPLY;
        state_next   = ST_AP_SWEEP;
      end
      ST_AP_SWEEP: begin
        cmd.kind = SW_APPLY;
        if (!status.sw_busy) begin
          state_next = ST_LV_NEXT;
        end
      end
      ST_LV_NEXT: begin
        cmd.lv_next = 1'b1;
        state_next  = ST_LV_CHECK;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/acmc_dp.sv @@
// Datapath of the mip chain builder: stores, filter, coverage counter and scale search.
module acmc_dp #(
  parameter int MAX_WIDTH       = 128,
  parameter int MAX_HEIGHT      = 128,
  parameter int BISECTION_STEPS = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_addr,
  input  logic [7:0]             cfg_data,
  input  logic [55:0]            s_tdata,
  input  acmc_pkg::acmc_cmd_t    cmd,
  output acmc_pkg::acmc_status_t status,
  input  logic                   m_tready,
  output logic                   m_tvalid,
  output logic [55:0]            m_tdata,
  output logic                   m_tuser
);
  import acmc_pkg::*;

  localparam int NB_MAX    = MAX_WIDTH * MAX_HEIGHT;
  localparam int MIP_DEPTH = NB_MAX / 2 + MAX_WIDTH + MAX_HEIGHT;
  localparam int AWB       = $clog2(NB_MAX);
  localparam int AWM       = $clog2(MIP_DEPTH);
  localparam int SAW       = (AWB > AWM) ? AWB : AWM;
  localparam int NBW       = $clog2(NB_MAX + 1);
  localparam int PW        = 2 * NBW;
  localparam int DMAX      = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DWB       = $clog2(DMAX + 1);
  localparam int LVL_N     = $clog2(DMAX);
  localparam int LVB       = $clog2(LVL_N + 1);
  localparam int STW       = $clog2(BISECTION_STEPS);
  localparam int LW        = 2 * DWB + NBW;
  localparam int RPW       = SCW + 8 - SCALE_FRAC;

  function automatic logic [DWB-1:0] clamp_dim(input logic [7:0] v,
                                               input logic [DWB+7:0] top);
    logic [DWB+7:0] vx;
    vx = (DWB+8)'(v);
    if (vx == '0) begin
      clamp_dim = DWB'(1);
    end else if (vx > top) begin
      clamp_dim = top[DWB-1:0];
    end else begin
      clamp_dim = vx[DWB-1:0];
    end
  endfunction

  // Configuration and load state.
  logic [7:0]       cfg_w, cfg_h;
  logic [NBW-1:0]   load_pos;
  logic [DWB-1:0]   cw_c, ch_c;
  logic [2*DWB-1:0] n_prod;
  logic             pos_ok;

  // Level geometry.
  logic [DWB-1:0] cur_w, cur_h, dw, dh;
  logic [NBW-1:0] nb, dn, bcc;
  logic [PW-1:0]  tgt;
  logic [2*DWB-1:0] dn_prod;
  logic           src_is_base;
  logic [SAW-1:0] src_off, off;
  logic [LVB-1:0] lv;
  logic [LVB+3:0] lv_x;
  logic [DWB-1:0] lvl_w [8];
  logic [DWB-1:0] lvl_h [8];
  logic [SAW-1:0] lvl_off [8];

  // Filter.
  logic [SAW-1:0] row0, row1, fl_addr;
  logic [DWB-1:0] fx;
  logic [NBW-1:0] fi;
  logic [9:0]     acc [4];
  logic [9:0]     acc_rnd [4];
  logic [31:0]    fl_out;

  // Scale search.
  logic [SCW-1:0] lo, hi, scale_a, scale_b;
  logic [SCW:0]   mid_sum;
  logic [STW-1:0] step;
  logic [NBW-1:0] cnt_a, cnt_b;
  logic [PW-1:0]  prod_n, pa, pb, da, db;
  logic           ge;

  // Sweep pipeline.
  logic           running, v1, v2, hi128;
  logic [NBW-1:0] idx, sw_len;
  logic [SAW-1:0] sw_addr, a1, a2;
  logic [31:0]    sw_d, d2, src_d;
  logic [SCW+7:0] p_a, p_b, rnd;
  logic [RPW-1:0] b_raw;
  logic [7:0]     b_fix;
  logic           cov_a, cov_b;

  // Read path.
  logic [2:0]       rl, rl_idx;
  logic [6:0]       rx, ry;
  logic             rvalid, rl_ok, inb;
  logic [DWB-1:0]   rw, rh;
  logic [SAW-1:0]   roff, rprod, rd_addr;
  logic [DWB+6:0]   rp_full;
  logic [DWB+6:0]   rw_x, rh_x;

  // Memories.
  logic           base_we, mip_we;
  logic [SAW-1:0] mip_waddr;
  logic [31:0]    mip_wdata, base_rd, mip_rd;
  logic [SAW-1:0] base_raddr, mip_raddr;

  assign cw_c   = clamp_dim(cfg_w, (DWB+8)'(MAX_WIDTH));
  assign ch_c   = clamp_dim(cfg_h, (DWB+8)'(MAX_HEIGHT));
  assign n_prod = cw_c * ch_c;
  assign pos_ok = LW'(load_pos) < LW'(n_prod);
  assign dn_prod = dw * dh;
  assign lv_x   = (LVB+4)'(lv);

  assign sw_len  = (cmd.kind == SW_BASE) ? nb : dn;
  assign sw_addr = (cmd.kind == SW_BASE) ? SAW'(idx) : off + SAW'(idx);
  assign fl_addr = (cmd.fl_k[1] ? row1 : row0) + SAW'({fx, 1'b0})
                   + SAW'(cmd.fl_k[0] && (cur_w != DWB'(1)));

  assign base_raddr = cmd.fl_read ? fl_addr : sw_addr;
  assign mip_raddr  = cmd.fl_read ? fl_addr : (running ? sw_addr : rd_addr);
  assign sw_d       = (cmd.kind == SW_BASE) ? base_rd : mip_rd;
  assign src_d      = src_is_base ? base_rd : mip_rd;
  assign base_we    = cmd.load && pos_ok;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      acc_rnd[c]        = acc[c] + 10'd2;
      fl_out[8*c +: 8]  = acc_rnd[c][9:2];
    end
  end

  // Apply the chosen scale; rounding never moves a texel across the cut.
  assign cov_a = p_a >= CUT_LIMIT;
  assign cov_b = p_b >= CUT_LIMIT;
  assign rnd   = p_a + ROUND_HALF;
  assign b_raw = rnd[SCW+7:SCALE_FRAC];
  always_comb begin
    if (cov_a) begin
      if (b_raw > RPW'(255)) begin
        b_fix = 8'd255;
      end else if (b_raw < RPW'(128)) begin
        b_fix = 8'd128;
      end else begin
        b_fix = b_raw[7:0];
      end
    end else if (b_raw > RPW'(127)) begin
      b_fix = 8'd127;
    end else begin
      b_fix = b_raw[7:0];
    end
  end

  always_comb begin
    mip_we    = 1'b0;
    mip_waddr = a2;
    mip_wdata = {b_fix, d2[23:0]};
    if (cmd.fl_write) begin
      mip_we    = 1'b1;
      mip_waddr = off + SAW'(fi);
      mip_wdata = fl_out;
    end else if (v2 && cmd.kind == SW_APPLY) begin
      mip_we = 1'b1;
    end
  end

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign rl_idx  = rl - 3'd1;
  assign rl_ok   = (rl != 3'd0) && ((LVB+4)'(rl) <= lv_x);
  assign rp_full = ry * rw;
  assign rw_x    = (DWB+7)'(rw);
  assign rh_x    = (DWB+7)'(rh);
  assign inb     = rvalid && ((DWB+7)'(rx) < rw_x) && ((DWB+7)'(ry) < rh_x);

  assign status.sw_busy  = running || v1 || v2;
  assign status.fl_last  = fi == (dn - NBW'(1));
  assign status.bs_last  = step == STW'(BISECTION_STEPS - 1);
  assign status.more     = (cur_w != DWB'(1)) || (cur_h != DWB'(1));
  assign status.out_free = !m_tvalid || m_tready;

  acmc_ram #(.WIDTH(TEXEL_W), .DEPTH(NB_MAX)) u_base_ram (
    .clk   (clk),
    .we    (base_we),
    .waddr (load_pos[AWB-1:0]),
    .wdata (s_tdata[31:0]),
    .raddr (base_raddr[AWB-1:0]),
    .rdata (base_rd)
  );

  acmc_ram #(.WIDTH(TEXEL_W), .DEPTH(MIP_DEPTH)) u_mip_ram (
    .clk   (clk),
    .we    (mip_we),
    .waddr (mip_waddr[AWM-1:0]),
    .wdata (mip_wdata),
    .raddr (mip_raddr[AWM-1:0]),
    .rdata (mip_rd)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w    <= 8'd1;
      cfg_h    <= 8'd1;
      load_pos <= '0;
      lv       <= '0;
      running  <= 1'b0;
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr) begin
          cfg_h <= cfg_data;
        end else begin
          cfg_w <= cfg_data;
        end
      end
      if (cmd.build_init) begin
        load_pos <= '0;
        lv       <= '0;
      end else begin
        if (base_we) begin
          load_pos <= load_pos + NBW'(1);
        end
        if (cmd.lv_next) begin
          lv <= lv + LVB'(1);
        end
      end
      if (cmd.sw_start) begin
        running <= 1'b1;
      end else if (running && idx == sw_len - NBW'(1)) begin
        running <= 1'b0;
      end
      v1 <= running;
      v2 <= v1;
      if (cmd.rd_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload and counters.
  always_ff @(posedge clk) begin
    if (cmd.build_init) begin
      cur_w       <= cw_c;
      cur_h       <= ch_c;
      nb          <= NBW'(n_prod);
      src_is_base <= 1'b1;
      src_off     <= '0;
      off         <= '0;
    end
    if (cmd.lv_init) begin
      dw   <= (cur_w >> 1) == '0 ? DWB'(1) : (cur_w >> 1);
      dh   <= (cur_h >> 1) == '0 ? DWB'(1) : (cur_h >> 1);
      fx   <= '0;
      fi   <= '0;
      row0 <= src_off;
      row1 <= src_off + ((cur_h != DWB'(1)) ? SAW'(cur_w) : '0);
    end
    if (cmd.lv_dn) begin
      dn <= NBW'(dn_prod);
    end
    if (cmd.lv_tgt) begin
      tgt <= bcc * dn;
    end
    if (cmd.fl_clr) begin
      for (int c = 0; c < 4; c++) begin
        acc[c] <= '0;
      end
    end else if (cmd.fl_acc) begin
      for (int c = 0; c < 4; c++) begin
        acc[c] <= acc[c] + 10'(src_d[8*c +: 8]);
      end
    end
    if (cmd.fl_write) begin
      fi <= fi + NBW'(1);
      if (fx == dw - DWB'(1)) begin
        fx   <= '0;
        row0 <= row0 + SAW'({cur_w, 1'b0});
        row1 <= row1 + SAW'({cur_w, 1'b0});
      end else begin
        fx <= fx + DWB'(1);
      end
    end
    if (cmd.bs_init) begin
      lo   <= '0;
      hi   <= SCALE_TOP;
      step <= '0;
    end
    if (cmd.bs_mid) begin
      scale_a <= mid_sum[SCW:1];
    end
    if (cmd.bs_mul) begin
      prod_n <= cnt_a * nb;
    end
    if (cmd.bs_upd) begin
      step <= step + STW'(1);
      if (prod_n < tgt) begin
        lo <= scale_a;
      end else begin
        hi <= scale_a;
      end
    end
    if (cmd.sel_load) begin
      scale_a <= lo;
      scale_b <= hi;
    end
    if (cmd.sel_mul) begin
      pa <= cnt_a * nb;
      pb <= cnt_b * nb;
    end
    if (cmd.sel_abs) begin
      da <= (pa >= tgt) ? pa - tgt : tgt - pa;
      db <= (pb >= tgt) ? pb - tgt : tgt - pb;
      ge <= {pa, 1'b0} >= {1'b0, tgt};
    end
    if (cmd.sel_dec) begin
      scale_a <= (ge && da <= db) ? lo : hi;
    end
    if (cmd.lv_next) begin
      if (lv_x < (LVB+4)'(8)) begin
        lvl_w[lv_x[2:0]]   <= dw;
        lvl_h[lv_x[2:0]]   <= dh;
        lvl_off[lv_x[2:0]] <= off;
      end
      src_off     <= off;
      off         <= off + SAW'(dn);
      src_is_base <= 1'b0;
      cur_w       <= dw;
      cur_h       <= dh;
    end

    // Sweep: issue, then multiply, then count or write back.
    if (cmd.sw_start) begin
      idx   <= '0;
      bcc   <= (cmd.kind == SW_BASE) ? '0 : bcc;
      cnt_a <= '0;
      cnt_b <= '0;
    end else if (running) begin
      idx <= idx + NBW'(1);
    end
    a1 <= sw_addr;
    if (v1) begin
      p_a   <= sw_d[31:24] * scale_a;
      p_b   <= sw_d[31:24] * scale_b;
      hi128 <= sw_d[31];
      d2    <= sw_d;
      a2    <= a1;
    end
    if (v2) begin
      if (cmd.kind == SW_BASE) begin
        bcc <= bcc + NBW'(hi128);
      end else if (cmd.kind == SW_COUNT) begin
        cnt_a <= cnt_a + NBW'(cov_a);
        cnt_b <= cnt_b + NBW'(cov_b);
      end
    end

    if (cmd.rd_latch) begin
      rl <= s_tdata[34:32];
      rx <= s_tdata[41:35];
      ry <= s_tdata[48:42];
    end
    if (cmd.rd_look) begin
      rvalid <= rl_ok;
      rw     <= rl_ok ? lvl_w[rl_idx] : '0;
      rh     <= rl_ok ? lvl_h[rl_idx] : '0;
      roff   <= lvl_off[rl_idx];
    end
    if (cmd.rd_mul) begin
      rprod <= SAW'(rp_full);
    end
    if (cmd.rd_issue) begin
      rd_addr <= roff + rprod + SAW'(rx);
    end
    if (cmd.rd_out) begin
      m_tdata[31:0]  <= inb ? mip_rd : 32'd0;
      m_tdata[38:32] <= rw_x[6:0];
      m_tdata[45:39] <= rh_x[6:0];
      m_tdata[48:46] <= lv_x[2:0];
      m_tdata[55:49] <= '0;
      m_tuser        <= inb;
    end
  end

endmodule

@@ hw/rtl/alpha_coverage_mip_chain.sv @@
// Top level of the coverage-preserving mip chain builder.
//
// Input channel s_*: with tuser low an item loads one RGBA base texel in
// raster order (tdata bits 31:0 = red, green, blue, alpha); tlast on a load
// starts building all mip levels. With tuser high the item reads one texel of
// a built level and returns exactly one result item on m_*; loads return none.
// Configuration: cfg_we writes cfg_data into image_width (cfg_addr 0) or
// image_height (cfg_addr 1). The user must write it only while the block is
// idle; the block itself does not enforce it. A read steps through lookup,
// multiply, address, wait and output, holding the input meanwhile. A build
// counts the base coverage over the nb base texels, then per level of dn
// texels runs setup, the filter (four reads of the single read port each),
// BISECTION_STEPS sweeps for the scale search, the final counts and choice,
// and the alpha pass.
// s_tready is low while a read or a build is in progress.
// Reset clears the load position, the level count and the output valid; the
// texel memories keep their contents. A stalled result holds m_tdata until
// taken, and a following read waits in its last step until the slot is free.
module alpha_coverage_mip_chain #(
  parameter int MAX_WIDTH       = 128,
  parameter int MAX_HEIGHT      = 128,
  parameter int BISECTION_STEPS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // in_red, in_green, in_blue, in_alpha, read_level, read_x, read_y, zero pad
  input  logic [55:0] s_tdata,
  // mode
  input  logic        s_tuser,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_red, out_green, out_blue, out_alpha, level_width, level_height,
  // level_total, zero pad
  output logic [55:0] m_tdata,
  // read_ok
  output logic        m_tuser
);
  import acmc_pkg::*;

  acmc_cmd_t    cmd;
  acmc_status_t status;

  acmc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .mode       (s_tuser),
    .last_texel (s_tlast),
    .status     (status),
    .cmd        (cmd),
    .s_tready   (s_tready)
  );

  acmc_dp #(
    .MAX_WIDTH       (MAX_WIDTH),
    .MAX_HEIGHT      (MAX_HEIGHT),
    .BISECTION_STEPS (BISECTION_STEPS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .status   (status),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

@@ hw/rtl/acmc_check.sv @@
// Port-level checks of the mip chain builder, bound to the top level.
module acmc_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic        m_tuser
);

  // A result that waits keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // A texel inside a built level always comes with that level's size.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[38:32] != 7'd0 && m_tdata[45:39] != 7'd0)
    else $error("read_ok without level size");

  // An unbuilt level returns no colors and no success.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[38:32] == 7'd0 |-> m_tdata[31:0] == 32'd0 && !m_tuser)
    else $error("bad level returned data");

  // A final base texel starts a build, so the next item is not taken at once.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser && s_tlast |=> !s_tready)
    else $error("input taken during build");

  // Reset empties the result slot.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind alpha_coverage_mip_chain acmc_check u_check (.*);
